### hw/rtl/planar_yuv420_to_packed_uyvy_macros.svh
// Assertion macros used by the file that checks this block.
`ifndef PLANAR_YUV420_TO_PACKED_UYVY_MACROS_SVH
`define PLANAR_YUV420_TO_PACKED_UYVY_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PY2U_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("py2u: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PY2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("py2u: next-cycle check failed");

`endif

### hw/rtl/py2u_pkg.sv
`default_nettype none
package py2u_pkg;

  // Default header length in bytes and the width of its counter.
  localparam int HEADER_BYTES_DEF = 64;
  localparam int HDR_CNT_W        = 7;

  // Header byte positions that carry the image dimensions.
  localparam logic [HDR_CNT_W-1:0] HDR_POS_W_HI = 7'd11;
  localparam logic [HDR_CNT_W-1:0] HDR_POS_W_LO = 7'd12;
  localparam logic [HDR_CNT_W-1:0] HDR_POS_H_HI = 7'd13;
  localparam logic [HDR_CNT_W-1:0] HDR_POS_H_LO = 7'd14;

  // Byte lane masks.
  localparam logic [3:0] BE_LUMA = 4'hF;
  localparam logic [3:0] BE_CR   = 4'h4;
  localparam logic [3:0] BE_CB   = 4'h1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 1'b1;

  localparam logic [31:0] FRAME_BASE_RST = 32'd0;
  localparam logic [15:0] LINE_PITCH_RST = 16'd3840;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Parsing phase, one-hot.
  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LUMA   = 5'b00010,
    PH_CR     = 5'b00100,
    PH_CB     = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  // One frame-store write.
  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [3:0]  byte_enables;
    logic        last_of_run;
    logic        image_done;
  } result_t;

  // Writes produced by one accepted byte.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage
`default_nettype wire

### hw/rtl/py2u_in_if.sv
`default_nettype none
interface py2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       image_start;

  modport source (output valid, output stream_byte, output image_start, input ready);
  modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface
`default_nettype wire

### hw/rtl/py2u_out_if.sv
`default_nettype none
interface py2u_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [31:0] write_data;
  logic [3:0]  byte_enables;
  logic        last_of_run;
  logic        image_done;

  modport source (output valid, output write_address, output write_data,
                  output byte_enables, output last_of_run, output image_done,
                  input ready);
  modport sink   (input valid, input write_address, input write_data,
                  input byte_enables, input last_of_run, input image_done,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/py2u_cfg_if.sv
`default_nettype none
interface py2u_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [py2u_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/py2u_parse.sv
`default_nettype none
module py2u_parse #(
  parameter int HEADER_BYTES = py2u_pkg::HEADER_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  py2u_in_if.sink            in_ch,
  input  wire logic          space,
  input  wire logic [31:0]   frame_base,
  input  wire logic [15:0]   line_pitch,
  output py2u_pkg::push_t    push
);

  localparam logic [py2u_pkg::HDR_CNT_W-1:0] HDR_END =
    py2u_pkg::HDR_CNT_W'(HEADER_BYTES - 1);

  // Next plane with data, skipping planes that hold no bytes.
  function automatic py2u_pkg::phase_t plane_after(input py2u_pkg::phase_t ph,
                                                   input logic [15:0] w,
                                                   input logic [15:0] h);
    py2u_pkg::phase_t p;
    logic             c_empty;
    begin
      p       = ph;
      c_empty = (w[15:1] == 15'd0) || (h[15:1] == 15'd0);
      if (p == py2u_pkg::PH_LUMA && (w == 16'd0 || h == 16'd0)) p = py2u_pkg::PH_CR;
      if (p == py2u_pkg::PH_CR && c_empty) p = py2u_pkg::PH_CB;
      if (p == py2u_pkg::PH_CB && c_empty) p = py2u_pkg::PH_DONE;
      return p;
    end
  endfunction

  py2u_pkg::phase_t                  phase_r, phase_nxt, eff_phase;
  logic [py2u_pkg::HDR_CNT_W-1:0]    hdr_cnt_r, hdr_cnt_nxt, eff_cnt;
  logic [15:0]                       img_w_r, img_w_nxt, eff_w;
  logic [15:0]                       img_h_r, img_h_nxt, eff_h;
  logic [15:0]                       row_r, row_nxt, eff_row;
  logic [15:0]                       col_r, col_nxt, eff_col;
  logic [7:0]                        held_r, held_nxt, eff_held;
  logic [31:0]                       row_base_r, row_base_nxt, eff_row_base;
  logic [31:0]                       col_addr_r, col_addr_nxt, eff_col_addr;
  logic                              accept;
  logic                              start;
  logic [16:0]                       col1;
  logic [16:0]                       row1;
  logic [16:0]                       half_w;
  logic [16:0]                       half_h;
  logic [7:0]                        b;
  logic                              c_empty;
  logic                              is_cr;
  logic [31:0]                       c_data;
  logic                              plane_end;
  py2u_pkg::phase_t                  plane_req;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;
  assign start       = in_ch.image_start;
  assign b           = in_ch.stream_byte;

  // A start mark clears the image state before the byte is parsed.
  assign eff_phase    = start ? py2u_pkg::PH_HEADER : phase_r;
  assign eff_cnt      = start ? '0 : hdr_cnt_r;
  assign eff_w        = start ? 16'd0 : img_w_r;
  assign eff_h        = start ? 16'd0 : img_h_r;
  assign eff_row      = start ? 16'd0 : row_r;
  assign eff_col      = start ? 16'd0 : col_r;
  assign eff_held     = start ? 8'd0 : held_r;
  assign eff_row_base = start ? 32'd0 : row_base_r;
  assign eff_col_addr = start ? 32'd0 : col_addr_r;

  assign col1    = {1'b0, eff_col} + 17'd1;
  assign row1    = {1'b0, eff_row} + 17'd1;
  assign half_w  = {2'b00, eff_w[15:1]};
  assign half_h  = {2'b00, eff_h[15:1]};
  assign c_empty = (eff_w[15:1] == 15'd0) || (eff_h[15:1] == 15'd0);
  assign is_cr   = (eff_phase == py2u_pkg::PH_CR);
  assign c_data  = is_cr ? {8'd0, b, 16'd0} : {24'd0, b};

  // Parse one byte and form the writes it causes.
  always_comb begin
    phase_nxt    = eff_phase;
    hdr_cnt_nxt  = eff_cnt;
    img_w_nxt    = eff_w;
    img_h_nxt    = eff_h;
    row_nxt      = eff_row;
    col_nxt      = eff_col;
    held_nxt     = eff_held;
    row_base_nxt = eff_row_base;
    col_addr_nxt = eff_col_addr;
    plane_end    = 1'b0;
    plane_req    = py2u_pkg::PH_DONE;
    push         = '0;

    unique case (eff_phase)
      py2u_pkg::PH_HEADER: begin
        case (eff_cnt)
          py2u_pkg::HDR_POS_W_HI: img_w_nxt[15:8] = b;
          py2u_pkg::HDR_POS_W_LO: img_w_nxt[7:0]  = b;
          py2u_pkg::HDR_POS_H_HI: img_h_nxt[15:8] = b;
          py2u_pkg::HDR_POS_H_LO: img_h_nxt[7:0]  = b;
          default: ;
        endcase
        hdr_cnt_nxt = eff_cnt + 1'b1;
        if (eff_cnt == HDR_END) begin
          plane_end = 1'b1;
          plane_req = py2u_pkg::PH_LUMA;
        end
      end
      py2u_pkg::PH_LUMA: begin
        if (!eff_col[0]) begin
          held_nxt = b;
        end else begin
          push.push0              = 1'b1;
          push.res0.write_address = eff_col_addr;
          push.res0.write_data    = {b, 8'd0, eff_held, 8'd0};
          push.res0.byte_enables  = py2u_pkg::BE_LUMA;
          push.res0.last_of_run   = 1'b1;
          push.res0.image_done    = (row1 == {1'b0, eff_h}) &&
                                    ({2'b00, eff_col[15:1]} + 17'd1 == half_w) &&
                                    c_empty;
          col_addr_nxt            = eff_col_addr + 32'd4;
        end
        col_nxt = col1[15:0];
        // End of a luma row.
        if (col1 >= {1'b0, eff_w}) begin
          col_nxt      = 16'd0;
          row_nxt      = row1[15:0];
          row_base_nxt = eff_row_base + {16'd0, line_pitch};
          col_addr_nxt = row_base_nxt;
          if (row1 >= {1'b0, eff_h}) begin
            plane_end = 1'b1;
            plane_req = py2u_pkg::PH_CR;
          end
        end
      end
      py2u_pkg::PH_CR, py2u_pkg::PH_CB: begin
        // Each chroma byte covers the same word on two destination rows.
        push.push0              = 1'b1;
        push.push1              = 1'b1;
        push.res0.write_address = eff_col_addr;
        push.res0.write_data    = c_data;
        push.res0.byte_enables  = is_cr ? py2u_pkg::BE_CR : py2u_pkg::BE_CB;
        push.res0.last_of_run   = 1'b0;
        push.res0.image_done    = 1'b0;
        push.res1.write_address = eff_col_addr + {16'd0, line_pitch};
        push.res1.write_data    = c_data;
        push.res1.byte_enables  = is_cr ? py2u_pkg::BE_CR : py2u_pkg::BE_CB;
        push.res1.last_of_run   = 1'b1;
        push.res1.image_done    = !is_cr && (row1 == half_h) && (col1 == half_w);
        col_nxt                 = col1[15:0];
        col_addr_nxt            = eff_col_addr + 32'd4;
        if (col1 >= half_w) begin
          col_nxt      = 16'd0;
          row_nxt      = row1[15:0];
          row_base_nxt = eff_row_base + {15'd0, line_pitch, 1'b0};
          col_addr_nxt = row_base_nxt;
          if (row1 >= half_h) begin
            plane_end = 1'b1;
            plane_req = is_cr ? py2u_pkg::PH_CB : py2u_pkg::PH_DONE;
          end
        end
      end
      py2u_pkg::PH_DONE: ;
      default: ;
    endcase

    // Start of a new plane: counters clear and the frame base is taken.
    if (plane_end) begin
      phase_nxt    = plane_after(plane_req, img_w_nxt, img_h_nxt);
      row_nxt      = 16'd0;
      col_nxt      = 16'd0;
      row_base_nxt = frame_base;
      col_addr_nxt = frame_base;
    end

    if (!accept) begin
      push.push0 = 1'b0;
      push.push1 = 1'b0;
    end
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= py2u_pkg::PH_HEADER;
      hdr_cnt_r  <= '0;
      img_w_r    <= 16'd0;
      img_h_r    <= 16'd0;
      row_r      <= 16'd0;
      col_r      <= 16'd0;
      held_r     <= 8'd0;
      row_base_r <= 32'd0;
      col_addr_r <= 32'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      img_w_r    <= img_w_nxt;
      img_h_r    <= img_h_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      held_r     <= held_nxt;
      row_base_r <= row_base_nxt;
      col_addr_r <= col_addr_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/py2u_outq.sv
`default_nettype none
module py2u_outq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire py2u_pkg::push_t push,
  output logic             space,
  py2u_out_if.source       out_ch
);

  py2u_pkg::result_t                entries_r [py2u_pkg::Q_DEPTH];
  logic [py2u_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [py2u_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [py2u_pkg::Q_PTR_W-1:0]     wr_ptr_p1;
  logic [py2u_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]                       n_push;
  logic                             pop;
  py2u_pkg::result_t                head;

  // Room for the two writes of a chroma byte.
  assign space     = (cnt_r <= py2u_pkg::Q_CNT_W'(py2u_pkg::Q_DEPTH - 2));
  assign pop       = out_ch.valid && out_ch.ready;
  assign n_push    = {1'b0, push.push0} + {1'b0, push.push1};
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  assign wr_ptr_nxt = wr_ptr_r + py2u_pkg::Q_PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + py2u_pkg::Q_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + py2u_pkg::Q_CNT_W'(n_push) - py2u_pkg::Q_CNT_W'(pop);

  // Head of the queue drives the result channel.
  assign head                 = entries_r[rd_ptr_r];
  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.write_address = head.write_address;
  assign out_ch.write_data    = head.write_data;
  assign out_ch.byte_enables  = head.byte_enables;
  assign out_ch.last_of_run   = head.last_of_run;
  assign out_ch.image_done    = head.image_done;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push.push0) entries_r[wr_ptr_r] <= push.res0;
    if (push.push1) entries_r[wr_ptr_p1] <= push.res1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/planar_yuv420_to_packed_uyvy.sv
`default_nettype none
// Converts a planar YUV 4:2:0 image file, fed one byte per request on in_ch,
// into frame-store write requests on out_ch in packed UYVY word form.
// The header gives width and height; luma byte pairs give full-word writes,
// each chroma byte gives two byte-lane writes on neighbouring rows.
// cfg_ch writes frame_base (index 0) and line_pitch (index 1); it is always
// ready and should be used only while no requests are in flight.
// Each write is registered in the result queue and offered on out_ch.
// Throughput: one byte per cycle while the queue has room; out_ch takes one
// write per cycle while ready, so chroma bytes, two writes each, are paced
// by the four-entry result queue between the parser and out_ch.
// When out_ch stalls the queue fills and in_ch drops ready once more than
// two writes are waiting; nothing is lost.
// Reset (synchronous, rst_n low) empties the queue, returns the parser to
// the header phase and sets frame_base to 0 and line_pitch to 3840.
// An image_start mark on any byte restarts parsing at header byte 0.
module planar_yuv420_to_packed_uyvy #(
  parameter int HEADER_BYTES = py2u_pkg::HEADER_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  py2u_in_if.sink      in_ch,
  py2u_out_if.source   out_ch,
  py2u_cfg_if.sink     cfg_ch
);

  `include "planar_yuv420_to_packed_uyvy_macros.svh"

  logic [31:0]      frame_base_r;
  logic [15:0]      line_pitch_r;
  logic             space;
  py2u_pkg::push_t  push;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= py2u_pkg::FRAME_BASE_RST;
      line_pitch_r <= py2u_pkg::LINE_PITCH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        py2u_pkg::CFG_FRAME_BASE: frame_base_r <= cfg_ch.data;
        py2u_pkg::CFG_LINE_PITCH: line_pitch_r <= cfg_ch.data[15:0];
      endcase
    end
  end

  py2u_parse #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .space      (space),
    .frame_base (frame_base_r),
    .line_pitch (line_pitch_r),
    .push       (push)
  );

  py2u_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

  // The final write of an image always closes its byte's run.
  `PY2U_ASSERT_IMP(a_done_is_last, clk, rst_n, out_ch.valid && out_ch.image_done, out_ch.last_of_run)
  // A Cb lane write carries nothing outside its lane.
  `PY2U_ASSERT_IMP(a_cb_lane_clean, clk, rst_n, out_ch.valid && out_ch.byte_enables == py2u_pkg::BE_CB, out_ch.write_data[31:8] == 24'd0)
  // A second write for one byte only comes with a first.
  `PY2U_ASSERT_IMP(a_pair_order, clk, rst_n, push.push1, push.push0)
  // After any push, out_ch has a write on offer in the following cycle.
  `PY2U_ASSERT_NEXT(a_push_shows, clk, rst_n, push.push0, out_ch.valid)

endmodule
`default_nettype wire
